// ===== design/adpc_pkg.sv =====
package adpc_pkg;

    // Field widths of the request and result channels.
    localparam int MODE_W   = 2;
    localparam int SAMPLE_W = 12;
    localparam int SCALED_W = 10;
    localparam int POS_W    = 10;
    localparam int TOL_W    = 12;

    // Configuration port layout.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Default length of the averaging ring.
    localparam int AVG_DEPTH_DEFAULT = 8;

    // Stable readings needed to end a limit search.
    localparam int STABLE_W = 2;
    localparam logic [STABLE_W-1:0] STABLE_NEEDED = 2'd3;

    // Raw samples are divided by four before they enter the ring.
    localparam int SAMPLE_SHIFT = 2;

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Mode codes. The unused code behaves as track.
    localparam mode_t MODE_TRACK      = 2'd0;
    localparam mode_t MODE_SEARCH_MIN = 2'd1;
    localparam mode_t MODE_SEARCH_MAX = 2'd2;

    // Register indexes on the configuration port.
    localparam cfg_idx_t REG_TARGET_POSITION = 2'd0;
    localparam cfg_idx_t REG_TOLERANCE       = 2'd1;

endpackage

// ===== design/adpc_if.sv =====
// Request channel: one potentiometer sample with its mode.
interface adpc_cmd_if;
    logic                          valid;
    logic                          ready;
    adpc_pkg::mode_t               mode;
    logic [adpc_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output mode, output sample, input ready);
    modport sink (input valid, input mode, input sample, output ready);
endinterface

// Result channel: drive commands, position and search report.
interface adpc_result_if;
    logic                          valid;
    logic                          ready;
    logic                          drive_right;
    logic                          drive_left;
    logic [adpc_pkg::POS_W-1:0]    position;
    logic                          search_done;
    logic [adpc_pkg::SAMPLE_W-1:0] limit_value;

    modport source (output valid, output drive_right, output drive_left, output position,
                    output search_done, output limit_value, input ready);
    modport sink (input valid, input drive_right, input drive_left, input position,
                  input search_done, input limit_value, output ready);
endinterface

// Configuration write channel.
interface adpc_cfg_if;
    logic                            valid;
    logic                            ready;
    adpc_pkg::cfg_idx_t              index;
    logic [adpc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/averaged_deadband_position_control_core.sv =====
// Averaged deadband position controller. Each request carries a 12-bit potentiometer
// sample and a mode. Track requests push sample/4 into a ring of the last AVG_DEPTH
// values and steer the motor toward the target position with a deadband of tolerance;
// search requests drive toward one end and report the raw extreme once three readings
// in a row show no move beyond the tolerance. One request is taken every cycle while the
// result side does not stall; a result passes through stages 1, 2 and 3 and the output
// register, and a stalled result side holds the pipeline and then the request side.
// The ring lives in a memory with one read and one write per cycle, and the running sum
// is kept in a register, so the ring read and sum update set the pipeline's first stage.
// The average is formed by a reciprocal multiply in the following two stages. The ring
// reads as all zeros after reset without any clearing pass. Configuration writes are
// always accepted and must be made while no request is in flight.
module averaged_deadband_position_control_core #(
    parameter int AVG_DEPTH = adpc_pkg::AVG_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    adpc_cmd_if.sink      cmd,
    adpc_result_if.source result,
    adpc_cfg_if.sink      cfg
);

    localparam int IDX_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W   = $clog2(AVG_DEPTH * 1023 + 1);
    localparam int DIV_L   = $clog2(AVG_DEPTH);
    localparam int SHIFT   = SUM_W + DIV_L;
    localparam int MULT_W  = SUM_W + 1;
    localparam int PROD_W  = SUM_W + MULT_W;
    localparam longint MULT_VAL = ((64'd1 << SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_VAL);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(AVG_DEPTH - 1);

    localparam int SAMPLE_W = adpc_pkg::SAMPLE_W;
    localparam int SCALED_W = adpc_pkg::SCALED_W;
    localparam int POS_W    = adpc_pkg::POS_W;
    localparam int TOL_W    = adpc_pkg::TOL_W;
    localparam int STABLE_W = adpc_pkg::STABLE_W;

    // Configuration registers.
    logic [POS_W-1:0] target_reg;
    logic [TOL_W-1:0] tolerance_reg;

    // Ring bookkeeping and search state.
    logic [IDX_W-1:0]    write_index_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic                search_active_reg;
    logic                search_toward_min_reg;
    logic [SAMPLE_W-1:0] extreme_reg;
    logic [STABLE_W-1:0] stable_count_reg;

    // Stage 1: ring read data arrives.
    logic                s1_valid_reg;
    adpc_pkg::mode_t     s1_mode_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [IDX_W-1:0]    s1_addr_reg;

    // Stage 2: updated sum and search decision.
    logic                s2_valid_reg;
    logic [SUM_W-1:0]    s2_sum_reg;
    logic                s2_track_reg;
    logic                s2_right_reg;
    logic                s2_left_reg;
    logic                s2_done_reg;
    logic [SAMPLE_W-1:0] s2_limit_reg;

    // Stage 3: reciprocal product.
    logic                s3_valid_reg;
    logic [PROD_W-1:0]   s3_prod_reg;
    logic                s3_track_reg;
    logic                s3_right_reg;
    logic                s3_left_reg;
    logic                s3_done_reg;
    logic [SAMPLE_W-1:0] s3_limit_reg;

    // Output register.
    logic                out_valid_reg;
    logic                out_right_reg;
    logic                out_left_reg;
    logic [POS_W-1:0]    out_pos_reg;
    logic                out_done_reg;
    logic [SAMPLE_W-1:0] out_limit_reg;

    logic load_out, fire3, load3, fire2, load2, fire1, load1, accept;
    logic cmd_track;
    logic [SCALED_W-1:0] ring_old;

    // Pipeline flow: a stage takes a new request when empty or when it moves on.
    always_comb
    begin
        load_out = !out_valid_reg || result.ready;
        fire3    = s3_valid_reg && load_out;
        load3    = !s3_valid_reg || fire3;
        fire2    = s2_valid_reg && load3;
        load2    = !s2_valid_reg || fire2;
        fire1    = s1_valid_reg && load2;
        load1    = !s1_valid_reg || fire1;
        accept   = cmd.valid && load1;
    end

    assign cmd.ready = load1;
    assign cfg.ready = 1'b1;
    assign cmd_track = (cmd.mode != adpc_pkg::MODE_SEARCH_MIN)
                    && (cmd.mode != adpc_pkg::MODE_SEARCH_MAX);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            tolerance_reg <= '0;
        end
        else if (cfg.valid)
        begin
            priority if (cfg.index == adpc_pkg::REG_TARGET_POSITION)
            begin
                target_reg <= cfg.data[POS_W-1:0];
            end
            else if (cfg.index == adpc_pkg::REG_TOLERANCE)
            begin
                tolerance_reg <= cfg.data[TOL_W-1:0];
            end
            else
            begin
                target_reg <= target_reg;
            end
        end
    end

    // Stage 1 logic: sum update and search step.
    logic                s1_track;
    logic                s1_to_min;
    logic [SCALED_W-1:0] s1_scaled;
    logic [SUM_W-1:0]    s1_sum_upd;
    logic                moved;
    logic [STABLE_W-1:0] count_inc;
    logic                search_active_next;
    logic                search_toward_min_next;
    logic [SAMPLE_W-1:0] extreme_next;
    logic [STABLE_W-1:0] stable_count_next;
    logic                s1_right, s1_left, s1_done;
    logic [SAMPLE_W-1:0] s1_limit;

    adpc_ring_mem #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (write_index_reg),
        .wr_en   (fire1 && s1_track),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_scaled),
        .rd_data (ring_old)
    );

    always_comb
    begin
        s1_track   = (s1_mode_reg != adpc_pkg::MODE_SEARCH_MIN)
                  && (s1_mode_reg != adpc_pkg::MODE_SEARCH_MAX);
        s1_to_min  = (s1_mode_reg == adpc_pkg::MODE_SEARCH_MIN);
        s1_scaled  = s1_sample_reg[SAMPLE_W-1:adpc_pkg::SAMPLE_SHIFT];
        s1_sum_upd = sum_reg - SUM_W'(ring_old) + SUM_W'(s1_scaled);

        if (s1_to_min)
        begin
            moved = ({1'b0, s1_sample_reg} + {1'b0, tolerance_reg}) < {1'b0, extreme_reg};
        end
        else
        begin
            moved = {1'b0, s1_sample_reg} > ({1'b0, extreme_reg} + {1'b0, tolerance_reg});
        end
        count_inc = stable_count_reg + STABLE_W'(1);

        search_active_next     = search_active_reg;
        search_toward_min_next = search_toward_min_reg;
        extreme_next           = extreme_reg;
        stable_count_next      = stable_count_reg;
        s1_right               = 1'b0;
        s1_left                = 1'b0;
        s1_done                = 1'b0;
        s1_limit               = '0;

        if (s1_track)
        begin
            // A track request cancels any search.
            search_active_next = 1'b0;
            stable_count_next  = '0;
        end
        else if (!search_active_reg || (search_toward_min_reg != s1_to_min))
        begin
            // First request of a search seeds the extreme.
            search_active_next     = 1'b1;
            search_toward_min_next = s1_to_min;
            extreme_next           = s1_sample_reg;
            stable_count_next      = '0;
            s1_left                = s1_to_min;
            s1_right               = !s1_to_min;
        end
        else if (moved)
        begin
            extreme_next      = s1_sample_reg;
            stable_count_next = '0;
            s1_left           = s1_to_min;
            s1_right          = !s1_to_min;
        end
        else if (count_inc == adpc_pkg::STABLE_NEEDED)
        begin
            // Enough stable readings: stop and report the limit.
            search_active_next = 1'b0;
            stable_count_next  = '0;
            s1_done            = 1'b1;
            s1_limit           = extreme_reg;
        end
        else
        begin
            stable_count_next = count_inc;
            s1_left           = s1_to_min;
            s1_right          = !s1_to_min;
        end
    end

    // Control state of the ring and search.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg       <= '0;
            sum_reg               <= '0;
            search_active_reg     <= 1'b0;
            search_toward_min_reg <= 1'b0;
            extreme_reg           <= '0;
            stable_count_reg      <= '0;
        end
        else
        begin
            if (accept && cmd_track)
            begin
                write_index_reg <= (write_index_reg == LAST_IDX) ? '0
                                 : write_index_reg + IDX_W'(1);
            end
            if (fire1)
            begin
                if (s1_track)
                begin
                    sum_reg <= s1_sum_upd;
                end
                search_active_reg     <= search_active_next;
                search_toward_min_reg <= search_toward_min_next;
                extreme_reg           <= extreme_next;
                stable_count_reg      <= stable_count_next;
            end
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load1)
            begin
                s1_valid_reg <= accept;
            end
            if (load2)
            begin
                s2_valid_reg <= fire1;
            end
            if (load3)
            begin
                s3_valid_reg <= fire2;
            end
            if (load_out)
            begin
                out_valid_reg <= fire3;
            end
        end
    end

    // Stage 3 logic: average and deadband compare.
    logic [POS_W-1:0] pos3;
    logic [POS_W-1:0] diff3;
    logic             out_right_next, out_left_next;

    always_comb
    begin
        pos3  = s3_prod_reg[SHIFT +: POS_W];
        diff3 = (target_reg > pos3) ? (target_reg - pos3) : (pos3 - target_reg);
        if (!s3_track_reg)
        begin
            out_right_next = s3_right_reg;
            out_left_next  = s3_left_reg;
        end
        else if ({{(TOL_W-POS_W){1'b0}}, diff3} <= tolerance_reg)
        begin
            out_right_next = 1'b0;
            out_left_next  = 1'b0;
        end
        else
        begin
            out_right_next = target_reg > pos3;
            out_left_next  = !(target_reg > pos3);
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg   <= cmd.mode;
            s1_sample_reg <= cmd.sample;
            s1_addr_reg   <= write_index_reg;
        end
        if (fire1)
        begin
            s2_sum_reg   <= s1_track ? s1_sum_upd : sum_reg;
            s2_track_reg <= s1_track;
            s2_right_reg <= s1_right;
            s2_left_reg  <= s1_left;
            s2_done_reg  <= s1_done;
            s2_limit_reg <= s1_limit;
        end
        if (fire2)
        begin
            s3_prod_reg  <= PROD_W'(s2_sum_reg) * PROD_W'(MULT);
            s3_track_reg <= s2_track_reg;
            s3_right_reg <= s2_right_reg;
            s3_left_reg  <= s2_left_reg;
            s3_done_reg  <= s2_done_reg;
            s3_limit_reg <= s2_limit_reg;
        end
        if (fire3)
        begin
            out_right_reg <= out_right_next;
            out_left_reg  <= out_left_next;
            out_pos_reg   <= pos3;
            out_done_reg  <= s3_done_reg;
            out_limit_reg <= s3_limit_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.drive_right = out_right_reg;
    assign result.drive_left  = out_left_reg;
    assign result.position    = out_pos_reg;
    assign result.search_done = out_done_reg;
    assign result.limit_value = out_limit_reg;

endmodule

// ===== design/adpc_ring_mem.sv =====
module adpc_ring_mem #(
    parameter int AVG_DEPTH = adpc_pkg::AVG_DEPTH_DEFAULT,
    localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [IDX_W-1:0]              rd_addr,
    input  logic                          wr_en,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic [adpc_pkg::SCALED_W-1:0] wr_data,
    output logic [adpc_pkg::SCALED_W-1:0] rd_data
);

    logic [adpc_pkg::SCALED_W-1:0] mem [AVG_DEPTH];
    logic [AVG_DEPTH-1:0]          valid_reg;
    logic [adpc_pkg::SCALED_W-1:0] mem_rd_reg;
    logic                          entry_valid_reg;
    logic                          bypass_reg;
    logic [adpc_pkg::SCALED_W-1:0] bypass_data_reg;

    // Memory write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered memory read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

    // Written-entry flags; an entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            entry_valid_reg <= 1'b0;
            bypass_reg      <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                entry_valid_reg <= valid_reg[rd_addr];
                bypass_reg      <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // A write to the entry being read in the same cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            bypass_data_reg <= wr_data;
        end
    end

    always_comb
    begin
        priority if (bypass_reg)
        begin
            rd_data = bypass_data_reg;
        end
        else if (entry_valid_reg)
        begin
            rd_data = mem_rd_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule
